### src/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Types, constants and helper functions shared by the route table files.
// ----------------------------------------------------------------------------
`default_nettype none

package art_pkg;

    localparam int TABLE_DEPTH  = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int RES_W        = 6;
    localparam logic [4:0] BAD_DISTANCE = 5'd31;

    typedef enum logic [1:0] {
        OP_TOUCH  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_PRUNE  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_LOOKUP  = 2'd1,
        KIND_DELETED = 2'd2,
        KIND_FULL    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DIRECT  = 2'd0,
        ST_GOOD    = 2'd1,
        ST_SUSPECT = 2'd2,
        ST_BAD     = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] first_net;
        logic [15:0] last_net;
        logic [15:0] hop_network;
        logic [7:0]  hop_node;
        logic [3:0]  port;
        logic [4:0]  distance;
        status_t     status;
    } route_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] first_net;
        logic [15:0] last_net;
        logic [15:0] hop_network;
        logic [7:0]  hop_node;
        logic [3:0]  port;
        logic [4:0]  distance;
        logic [15:0] lookup_network;
    } request_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        found;
        logic [15:0] out_range_start;
        logic [15:0] out_range_end;
        logic [15:0] out_hop_network;
        logic [7:0]  out_hop_node;
        logic [3:0]  out_port;
        logic [4:0]  out_distance;
        logic        last;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_RD, S_T_EX, S_T_CHK,
        S_I_RD, S_I_EX,
        S_L_RD, S_L_EX,
        S_P_RD, S_P_EX,
        S_B_RD, S_B_EX,
        S_G_RD, S_G_EX,
        S_C_RD, S_C_EX
    } state_t;

    function automatic logic same_but_distance(input route_t a, input route_t b);
        return a.first_net == b.first_net && a.last_net == b.last_net &&
               a.hop_network == b.hop_network && a.hop_node == b.hop_node &&
               a.port == b.port;
    endfunction

    function automatic logic covers(input route_t a, input logic [15:0] net);
        return net >= a.first_net && net <= a.last_net;
    endfunction

    function automatic result_t make_result(input kind_t kind, input logic fnd,
                                            input route_t r, input logic lst);
        result_t o;
        o.result_kind     = kind;
        o.found           = fnd;
        o.out_range_start = r.first_net;
        o.out_range_end   = r.last_net;
        o.out_hop_network = r.hop_network;
        o.out_hop_node    = r.hop_node;
        o.out_port        = r.port;
        o.out_distance    = r.distance;
        o.last            = lst;
        return o;
    endfunction

endpackage

`default_nettype wire

### src/aging_route_table.sv
// ----------------------------------------------------------------------------
// aging_route_table
// Distance-ordered routing table with touch, lookup and ageing prune.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low; busy stays high until
// all its results are out. Results come on result, marked by result_strobe
// for one cycle, and cannot be held off. Each table entry is read, then
// modified/written, on the route memory. A touch makes a compaction pass,
// then an insert pass; a lookup makes one scan; a prune makes an ageing pass,
// a pass that writes back the B routes demoted to bad, and a pass for each
// of the G deleted routes: each deleted range is checked against every
// remaining entry for cover. A second memory holds demoted and deleted
// routes during a prune. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_route_table #(
    parameter int TABLE_DEPTH = art_pkg::TABLE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire art_pkg::request_t  request,
    output logic                    result_strobe,
    output art_pkg::result_t        result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL     = CW'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
    localparam logic [art_pkg::RES_W-1:0] RES_CAP = art_pkg::RES_W'(art_pkg::MAX_RESULTS);

    art_pkg::state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [CW-1:0] nb_reg, nb_next;
    logic [CW-1:0] ng_reg, ng_next;
    logic [CW-1:0] gk_reg, gk_next;
    logic [art_pkg::RES_W-1:0] nres_reg, nres_next;
    logic          found_reg, found_next;
    logic          ins_reg, ins_next;
    logic          pend_reg, pend_next;
    logic          strobe_reg, strobe_next;

    art_pkg::request_t req_reg, req_next;
    art_pkg::route_t   carry_reg, carry_next;
    art_pkg::route_t   gone_reg, gone_next;
    art_pkg::route_t   pendr_reg, pendr_next;
    art_pkg::result_t  res_reg, res_next;

    logic               tbl_we, aux_we;
    logic [AW-1:0]      tbl_waddr, aux_waddr, tbl_raddr, aux_raddr;
    art_pkg::route_t    tbl_wdata, aux_wdata, tbl_rdata, aux_rdata;

    art_pkg::route_t req_route, new_route, zero_route;
    logic            rd_end, same_hit, cov_hit, lk_hit;

    always_comb
    begin
        req_route.first_net   = req_reg.first_net;
        req_route.last_net    = req_reg.last_net;
        req_route.hop_network = req_reg.hop_network;
        req_route.hop_node    = req_reg.hop_node;
        req_route.port        = req_reg.port;
        req_route.distance    = req_reg.distance;
        req_route.status      = art_pkg::ST_GOOD;
        new_route = req_route;
        if (req_reg.distance == 5'd0)
        begin
            new_route.status = art_pkg::ST_DIRECT;
        end
        else if (req_reg.distance == art_pkg::BAD_DISTANCE)
        begin
            new_route.status = art_pkg::ST_BAD;
        end
        zero_route = '0;
    end

    assign rd_end   = (rd_reg == cnt_reg);
    assign same_hit = !found_reg && art_pkg::same_but_distance(tbl_rdata, req_route);
    assign cov_hit  = art_pkg::covers(tbl_rdata, gone_reg.first_net);
    assign lk_hit   = art_pkg::covers(tbl_rdata, req_reg.lookup_network);

    assign busy          = (state_reg != art_pkg::S_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = res_reg;

    art_ram #(.DEPTH(TABLE_DEPTH)) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    art_ram #(.DEPTH(TABLE_DEPTH)) u_aux (
        .clk   (clk),
        .we    (aux_we),
        .waddr (aux_waddr),
        .wdata (aux_wdata),
        .raddr (aux_raddr),
        .rdata (aux_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            art_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (request.opcode)
                        art_pkg::OP_TOUCH:  state_next = art_pkg::S_T_RD;
                        art_pkg::OP_LOOKUP: state_next = art_pkg::S_L_RD;
                        art_pkg::OP_PRUNE:  state_next = art_pkg::S_P_RD;
                        default:            state_next = art_pkg::S_IDLE;
                    endcase
                end
            end
            art_pkg::S_T_RD:  state_next = rd_end ? art_pkg::S_T_CHK : art_pkg::S_T_EX;
            art_pkg::S_T_EX:  state_next = art_pkg::S_T_RD;
            art_pkg::S_T_CHK:
            begin
                if (found_reg || cnt_reg == FULL)
                begin
                    state_next = art_pkg::S_IDLE;
                end
                else
                begin
                    state_next = art_pkg::S_I_RD;
                end
            end
            art_pkg::S_I_RD:  state_next = rd_end ? art_pkg::S_IDLE : art_pkg::S_I_EX;
            art_pkg::S_I_EX:  state_next = art_pkg::S_I_RD;
            art_pkg::S_L_RD:  state_next = rd_end ? art_pkg::S_IDLE : art_pkg::S_L_EX;
            art_pkg::S_L_EX:  state_next = lk_hit ? art_pkg::S_IDLE : art_pkg::S_L_RD;
            art_pkg::S_P_RD:  state_next = rd_end ? art_pkg::S_B_RD : art_pkg::S_P_EX;
            art_pkg::S_P_EX:  state_next = art_pkg::S_P_RD;
            art_pkg::S_B_RD:
                state_next = (rd_reg == nb_reg) ? art_pkg::S_G_RD : art_pkg::S_B_EX;
            art_pkg::S_B_EX:  state_next = art_pkg::S_B_RD;
            art_pkg::S_G_RD:
            begin
                if (gk_reg == ng_reg || nres_reg == RES_CAP)
                begin
                    state_next = art_pkg::S_IDLE;
                end
                else
                begin
                    state_next = art_pkg::S_G_EX;
                end
            end
            art_pkg::S_G_EX:  state_next = art_pkg::S_C_RD;
            art_pkg::S_C_RD:  state_next = rd_end ? art_pkg::S_G_RD : art_pkg::S_C_EX;
            art_pkg::S_C_EX:  state_next = cov_hit ? art_pkg::S_G_RD : art_pkg::S_C_RD;
            default:          state_next = art_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next    = cnt_reg;
        rd_next     = rd_reg;
        wr_next     = wr_reg;
        nb_next     = nb_reg;
        ng_next     = ng_reg;
        gk_next     = gk_reg;
        nres_next   = nres_reg;
        found_next  = found_reg;
        ins_next    = ins_reg;
        pend_next   = pend_reg;
        strobe_next = 1'b0;
        req_next    = req_reg;
        carry_next  = carry_reg;
        gone_next   = gone_reg;
        pendr_next  = pendr_reg;
        res_next    = res_reg;

        tbl_we    = 1'b0;
        tbl_waddr = wr_reg[AW-1:0];
        tbl_wdata = tbl_rdata;
        tbl_raddr = rd_reg[AW-1:0];
        aux_we    = 1'b0;
        aux_waddr = nb_reg[AW-1:0];
        aux_wdata = tbl_rdata;
        aux_raddr = rd_reg[AW-1:0];

        unique case (state_reg)
            art_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    rd_next    = '0;
                    wr_next    = '0;
                    nb_next    = '0;
                    ng_next    = '0;
                    found_next = 1'b0;
                end
            end
            art_pkg::S_T_RD:
            begin
                if (rd_end)
                begin
                    cnt_next = wr_reg;
                end
            end
            art_pkg::S_T_EX:
            begin
                rd_next = rd_reg + 1'b1;
                if (same_hit && tbl_rdata.distance != req_reg.distance)
                begin
                    // same route at another distance: drop it
                    tbl_we = 1'b0;
                end
                else
                begin
                    tbl_we  = 1'b1;
                    wr_next = wr_reg + 1'b1;
                    if (same_hit)
                    begin
                        found_next = 1'b1;
                        if (req_reg.distance != art_pkg::BAD_DISTANCE)
                        begin
                            tbl_wdata.status = art_pkg::ST_GOOD;
                        end
                    end
                end
            end
            art_pkg::S_T_CHK:
            begin
                rd_next  = '0;
                ins_next = 1'b0;
                if (!found_reg && cnt_reg == FULL)
                begin
                    strobe_next = 1'b1;
                    res_next = art_pkg::make_result(art_pkg::KIND_FULL, 1'b0,
                                                    req_route, 1'b1);
                end
            end
            art_pkg::S_I_RD:
            begin
                if (rd_end)
                begin
                    tbl_we      = 1'b1;
                    tbl_waddr   = cnt_reg[AW-1:0];
                    tbl_wdata   = ins_reg ? carry_reg : new_route;
                    cnt_next    = cnt_reg + 1'b1;
                    strobe_next = 1'b1;
                    res_next = art_pkg::make_result(art_pkg::KIND_INSERT, 1'b0,
                                                    new_route, 1'b1);
                end
            end
            art_pkg::S_I_EX:
            begin
                rd_next   = rd_reg + 1'b1;
                tbl_waddr = rd_reg[AW-1:0];
                if (ins_reg)
                begin
                    tbl_we     = 1'b1;
                    tbl_wdata  = carry_reg;
                    carry_next = tbl_rdata;
                end
                else if (tbl_rdata.distance > req_reg.distance)
                begin
                    tbl_we     = 1'b1;
                    tbl_wdata  = new_route;
                    carry_next = tbl_rdata;
                    ins_next   = 1'b1;
                end
            end
            art_pkg::S_L_RD:
            begin
                if (rd_end)
                begin
                    strobe_next = 1'b1;
                    res_next = art_pkg::make_result(art_pkg::KIND_LOOKUP, 1'b0,
                                                    zero_route, 1'b1);
                end
            end
            art_pkg::S_L_EX:
            begin
                rd_next = rd_reg + 1'b1;
                if (lk_hit)
                begin
                    strobe_next = 1'b1;
                    res_next = art_pkg::make_result(art_pkg::KIND_LOOKUP, 1'b1,
                                                    tbl_rdata, 1'b1);
                end
            end
            art_pkg::S_P_RD:
            begin
                if (rd_end)
                begin
                    cnt_next = wr_reg;
                    rd_next  = '0;
                end
            end
            art_pkg::S_P_EX:
            begin
                rd_next = rd_reg + 1'b1;
                case (tbl_rdata.status)
                    art_pkg::ST_DIRECT:
                    begin
                        tbl_we  = 1'b1;
                        wr_next = wr_reg + 1'b1;
                    end
                    art_pkg::ST_GOOD:
                    begin
                        tbl_we           = 1'b1;
                        tbl_wdata.status = art_pkg::ST_SUSPECT;
                        wr_next          = wr_reg + 1'b1;
                    end
                    art_pkg::ST_SUSPECT:
                    begin
                        aux_we             = 1'b1;
                        aux_wdata.status   = art_pkg::ST_BAD;
                        aux_wdata.distance = art_pkg::BAD_DISTANCE;
                        nb_next            = nb_reg + 1'b1;
                    end
                    default:
                    begin
                        // deleted routes fill the spare memory from the top down
                        aux_we    = 1'b1;
                        aux_waddr = LAST_IDX - ng_reg[AW-1:0];
                        ng_next   = ng_reg + 1'b1;
                    end
                endcase
            end
            art_pkg::S_B_RD:
            begin
                if (rd_reg == nb_reg)
                begin
                    cnt_next  = cnt_reg + nb_reg;
                    gk_next   = '0;
                    nres_next = '0;
                    pend_next = 1'b0;
                end
            end
            art_pkg::S_B_EX:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = AW'(cnt_reg + rd_reg);
                tbl_wdata = aux_rdata;
                rd_next   = rd_reg + 1'b1;
            end
            art_pkg::S_G_RD:
            begin
                aux_raddr = LAST_IDX - gk_reg[AW-1:0];
                if (gk_reg == ng_reg || nres_reg == RES_CAP)
                begin
                    if (pend_reg)
                    begin
                        strobe_next = 1'b1;
                        res_next = art_pkg::make_result(art_pkg::KIND_DELETED, 1'b0,
                                                        pendr_reg, 1'b1);
                    end
                end
            end
            art_pkg::S_G_EX:
            begin
                gone_next = aux_rdata;
                rd_next   = '0;
            end
            art_pkg::S_C_RD:
            begin
                if (rd_end)
                begin
                    // uncovered: hold it back until we know whether it is last
                    if (pend_reg)
                    begin
                        strobe_next = 1'b1;
                        res_next = art_pkg::make_result(art_pkg::KIND_DELETED, 1'b0,
                                                        pendr_reg, 1'b0);
                    end
                    pend_next  = 1'b1;
                    pendr_next = gone_reg;
                    nres_next  = nres_reg + 1'b1;
                    gk_next    = gk_reg + 1'b1;
                end
            end
            art_pkg::S_C_EX:
            begin
                rd_next = rd_reg + 1'b1;
                if (cov_hit)
                begin
                    gk_next = gk_reg + 1'b1;
                end
            end
            default:
            begin
                tbl_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= art_pkg::S_IDLE;
            cnt_reg    <= '0;
            rd_reg     <= '0;
            wr_reg     <= '0;
            nb_reg     <= '0;
            ng_reg     <= '0;
            gk_reg     <= '0;
            nres_reg   <= '0;
            found_reg  <= 1'b0;
            ins_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_reg     <= rd_next;
            wr_reg     <= wr_next;
            nb_reg     <= nb_next;
            ng_reg     <= ng_next;
            gk_reg     <= gk_next;
            nres_reg   <= nres_next;
            found_reg  <= found_next;
            ins_reg    <= ins_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        carry_reg <= carry_next;
        gone_reg  <= gone_next;
        pendr_reg <= pendr_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

### src/art_ram.sv
// ----------------------------------------------------------------------------
// art_ram
// Route store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module art_ram #(
    parameter int DEPTH = art_pkg::TABLE_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire art_pkg::route_t            wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output art_pkg::route_t                 rdata
);

    art_pkg::route_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
